// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define BNE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bne_pkg.sv =====
`default_nettype none

package bne_pkg;

  localparam int MAX_SIZE   = 256;
  localparam int MAX_DIAG   = 15;
  localparam int SIZE_W     = 9;
  localparam int DIAG_W     = 4;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 64;
  localparam int CALC_W     = 11;
  localparam int BAND_DEPTH = MAX_SIZE * MAX_DIAG;
  localparam int BAND_AW    = $clog2(BAND_DEPTH);
  localparam int CFG_AW     = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SIZE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DIAG = 2'd1;

  localparam logic [SIZE_W-1:0] SIZE_RST = 9'd256;
  localparam logic [DIAG_W-1:0] DIAG_RST = 4'd3;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_PROD   = 2'd2,
    ACT_RHS    = 2'd3
  } action_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted word
    logic setup;     // decode, write stores, compute the row range
    logic issue;     // read one band row and advance the row counter
    logic out_load;  // move the finished sum into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_load;
    logic skip;      // request out of band/size, or empty row range
    logic last;      // row counter sits on the last row
    logic busy;      // multiply-accumulate pipe still holds work
    logic out_free;  // output register empty or being drained
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/banded_normal_equations.sv =====
// Banded normal-equation builder. Load words (tuser 0 and 1) write one
// entry of the k-diagonal matrix A or of the vector b; entries outside the
// current size or band are dropped and produce no result. Request words
// (tuser 2 and 3) return one entry of A'A at (row, col) or of A'b at row as
// a saturating signed Q32.32 sum of Q16.16 products; a request outside the
// size, or a product entry more than k/2 off the diagonal, returns error
// status with a zero sum. The block works on one word at a time: a load
// is captured, then decoded and written; a request is captured, decoded,
// walks L band rows (L at most k, at most 15), one row per cycle through
// the dual-read band store and a registered multiply-accumulate pipe,
// then drains the pipe, hands off its result and returns to idle; a
// request refused for band or size, or one whose row range is empty,
// skips the walk and the drain. A finished result
// sits in the output register, so loads keep flowing while the result
// waits to be taken; the next request holds in its hand-off cycle until
// that register is taken. Both stores power up undefined: every entry a
// request touches must be loaded first. Write configuration only while the
// block is idle.
`default_nettype none

module banded_normal_equations (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [bne_pkg::CFG_AW-1:0]         cfg_addr_i,   // 0 size, 1 diagonals
  input  logic [bne_pkg::SIZE_W-1:0]         cfg_data_i,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [bne_pkg::IN_DATA_W-1:0]      s_axis_tdata, // row[7:0] col[15:8] value[47:16]
  input  logic [1:0]                         s_axis_tuser, // action[1:0]
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [bne_pkg::OUT_DATA_W-1:0]     m_axis_tdata, // row[7:0] col[15:8] sum[79:16]
  output logic                               m_axis_tuser  // status[0]
);
  import bne_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequence each word: capture, decode and, for a request, walk the band rows, drain, hand off
  bne_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // config registers, band and b stores, MAC pipe and output register
  bne_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i),
    .s_user_i  (s_axis_tuser),
    .s_data_i  (s_axis_tdata),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_user_o  (m_axis_tuser),
    .m_data_o  (m_axis_tdata),
    .cmd_i     (cmd),
    .stat_o    (stat)
  );

endmodule

`default_nettype wire

// ===== sv/bne_ctrl.sv =====
`default_nettype none

module bne_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  bne_pkg::dp_stat_t  stat_i,
  output bne_pkg::ctrl_cmd_t cmd_o
);
  import bne_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    s_ready_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (stat_i.is_load) state_d = ST_IDLE;
        else if (stat_i.skip) state_d = ST_DONE;
        else state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

`default_nettype wire

// ===== sv/bne_dp.sv =====
`default_nettype none

module bne_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bne_pkg::CFG_AW-1:0]          cfg_addr_i,
  input  logic [bne_pkg::SIZE_W-1:0]          cfg_data_i,
  input  logic [1:0]                          s_user_i,
  input  logic [bne_pkg::IN_DATA_W-1:0]       s_data_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic                                m_user_o,
  output logic [bne_pkg::OUT_DATA_W-1:0]      m_data_o,
  input  bne_pkg::ctrl_cmd_t                  cmd_i,
  output bne_pkg::dp_stat_t                   stat_o
);
  import bne_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration
  logic [SIZE_W-1:0] size_q;
  logic [DIAG_W-1:0] diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
      diag_q <= DIAG_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_SIZE) size_q <= cfg_data_i;
      if (cfg_addr_i == REG_DIAG) diag_q <= cfg_data_i[DIAG_W-1:0];
    end
  end

  // captured request
  action_e           act_q;
  logic [IDX_W-1:0]  row_q, col_q;
  logic [VAL_W-1:0]  val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_e'(s_user_i);
      row_q <= s_data_i[IDX_W-1:0];
      col_q <= s_data_i[2*IDX_W-1:IDX_W];
      val_q <= s_data_i[2*IDX_W+VAL_W-1:2*IDX_W];
    end
  end

  // decode and row range
  logic [SIZE_W-1:0] n_eff;
  logic [DIAG_W-1:0] k_eff, half;
  logic signed [CALC_W-1:0] r_s, c_s, n_s, k_s, h_s, mx_s, mn_s, d_s;
  logic signed [CALC_W-1:0] top_s, bot_s, lo_s, hi_s;
  logic is_rhs, bad, empty, ok_a, ok_b;

  always_comb begin
    n_eff  = (size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;
    k_eff  = (diag_q > DIAG_W'(MAX_DIAG)) ? DIAG_W'(MAX_DIAG) : diag_q;
    half   = k_eff >> 1;
    r_s    = CALC_W'(row_q);
    c_s    = CALC_W'(col_q);
    n_s    = CALC_W'(n_eff);
    k_s    = CALC_W'(k_eff);
    h_s    = CALC_W'(half);
    is_rhs = (act_q == ACT_RHS);
    mx_s   = (!is_rhs && c_s > r_s) ? c_s : r_s;
    mn_s   = (!is_rhs && c_s < r_s) ? c_s : r_s;
    d_s    = c_s - r_s + h_s;
    ok_a   = (r_s < n_s) && (c_s < n_s) && (d_s >= 0) && (d_s < k_s);
    ok_b   = (r_s < n_s);
    if (is_rhs) bad = (r_s >= n_s);
    else bad = (r_s >= n_s) || (c_s >= n_s) || ((mx_s - mn_s) > h_s);
    top_s  = mn_s + h_s;
    bot_s  = mx_s + h_s - (k_s - CALC_W'(1));
    lo_s   = (bot_s < 0) ? '0 : bot_s;
    hi_s   = (top_s > n_s - CALC_W'(1)) ? n_s - CALC_W'(1) : top_s;
    empty  = (lo_s > hi_s);
  end

  // row walk
  logic [IDX_W-1:0] l_q, hi_q;
  logic             bad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      l_q   <= lo_s[IDX_W-1:0];
      hi_q  <= hi_s[IDX_W-1:0];
      bad_q <= bad;
    end else if (cmd_i.issue) begin
      l_q <= l_q + IDX_W'(1);
    end
  end

  // band store address of A(l, x) is l*MAX_DIAG + (x - l + half)
  logic [BAND_AW-1:0] wr_addr, rd_addr_a, rd_addr_b, row_base;
  logic               band_we, rhs_we;

  always_comb begin
    wr_addr   = BAND_AW'(row_q) * BAND_AW'(MAX_DIAG) + BAND_AW'(d_s[DIAG_W-1:0]);
    row_base  = BAND_AW'(l_q) * BAND_AW'(MAX_DIAG - 1) + BAND_AW'(half);
    rd_addr_a = row_base + BAND_AW'(row_q);
    rd_addr_b = row_base + BAND_AW'(col_q);
    band_we   = cmd_i.setup && (act_q == ACT_LOAD_A) && ok_a;
    rhs_we    = cmd_i.setup && (act_q == ACT_LOAD_B) && ok_b;
  end

  logic [VAL_W-1:0] band_mem [BAND_DEPTH];
  logic [VAL_W-1:0] rhs_mem  [MAX_SIZE];
  logic [VAL_W-1:0] rd_a_q, rd_b_q, rd_rhs_q;

  always_ff @(posedge clk_i) begin
    if (band_we) band_mem[wr_addr] <= val_q;
    rd_a_q <= band_mem[rd_addr_a];
    rd_b_q <= band_mem[rd_addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (rhs_we) rhs_mem[row_q] <= val_q;
    rd_rhs_q <= rhs_mem[l_q];
  end

  // multiply, then saturating accumulate
  logic                    v1_q, v2_q;
  logic signed [VAL_W-1:0] op_a, op_b;
  logic signed [SUM_W-1:0] prod_d, prod_q, acc_q, acc_d, sum_w;
  logic                    ovf;

  always_comb begin
    op_a   = rd_a_q;
    op_b   = is_rhs ? rd_rhs_q : rd_b_q;
    prod_d = op_a * op_b;
    sum_w  = acc_q + prod_q;
    ovf    = (acc_q[SUM_W-1] == prod_q[SUM_W-1]) && (sum_w[SUM_W-1] != acc_q[SUM_W-1]);
    if (ovf) acc_d = acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX;
    else acc_d = sum_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) prod_q <= prod_d;
    if (cmd_i.setup) acc_q <= '0;
    else if (v2_q) acc_q <= acc_d;
  end

  // output register
  logic                m_valid_q;
  logic                out_status_q;
  logic [IDX_W-1:0]    out_row_q, out_col_q;
  logic [SUM_W-1:0]    out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (cmd_i.out_load) m_valid_q <= 1'b1;
    else if (m_ready_i) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= bad_q;
      out_row_q    <= row_q;
      out_col_q    <= is_rhs ? '0 : col_q;
      out_sum_q    <= bad_q ? '0 : acc_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_user_o  = out_status_q;
  assign m_data_o  = {out_sum_q, out_col_q, out_row_q};

  assign stat_o.is_load  = (act_q == ACT_LOAD_A) || (act_q == ACT_LOAD_B);
  assign stat_o.skip     = bad || empty;
  assign stat_o.last     = (l_q == hi_q);
  assign stat_o.busy     = v1_q || v2_q;
  assign stat_o.out_free = !m_valid_q || m_ready_i;

endmodule

`default_nettype wire

// ===== sv/bne_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module bne_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [1:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic                           m_axis_tuser,
  input logic [bne_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result holds its word
  `BNE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // an error result carries a zero sum
  `BNE_ASSERT(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[79:16] == 64'd0, "error result with nonzero sum")

  // one word at a time: ready drops after each accept
  `BNE_ASSERT(a_one_word, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready held after accept")

  // a new result appears only while the block is busy on a request
  `BNE_ASSERT(a_rise_busy, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result appeared while idle")

  // the request action field is never unknown once accepted
  `BNE_ASSERT_ALWAYS(a_act_known, clk_i, !(rst_ni && s_axis_tvalid && s_axis_tready) || !$isunknown(s_axis_tuser), "unknown action accepted")

endmodule

bind banded_normal_equations bne_checker u_bne_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bne_pkg::*;

  // cycles with no word moving on either stream before the run is abandoned
  localparam int STALL_LIMIT = 5000;
  // a request walks at most 15 band rows; give it room
  localparam int SETTLE = 32;
  // indexes past the register list, written once to show they are ignored
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic        status;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [63:0] sum;
  } entry_t;

  // directed word; typed rows carry their own expected status and sum
  typedef struct packed {
    action_e     act;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
    bit          typed;
    logic        status;
    logic [63:0] sum;
  } probe_t;

  // one configuration setting: rows at each end of the matrix to fill,
  // random words to send, and whether the fill uses the saturating extremes
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [DIAG_W-1:0] diag;
    int                rim_rows;
    int                random_words;
    bit                hot;
  } phase_t;

  localparam int PROBES = 24;
  // runs under the reset setting: n = 256, k = 3, half bandwidth 1
  localparam probe_t SCRIPT [PROBES] = '{
    '{ACT_LOAD_A, 8'd0,   8'd0,   32'h8000_0000, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_A, 8'd1,   8'd0,   32'h8000_0000, 1'b0, 1'b0, 64'd0},
    // two products of 2^62 overflow by one: clamp to the largest value
    '{ACT_PROD,   8'd0,   8'd0,   32'h0,         1'b1, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF},
    '{ACT_LOAD_B, 8'd0,   8'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_B, 8'd1,   8'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, 64'd0},
    // rhs request with a nonzero column: the result column reads zero
    '{ACT_RHS,    8'd0,   8'hFF,  32'h0,         1'b0, 1'b0, 64'd0},
    // more than half bandwidth off the diagonal: error status, zero sum
    '{ACT_PROD,   8'd0,   8'd5,   32'h0,         1'b1, 1'b1, 64'd0},
    '{ACT_PROD,   8'd200, 8'd197, 32'h0,         1'b1, 1'b1, 64'd0},
    // load outside the band: dropped, no result
    '{ACT_LOAD_A, 8'd0,   8'd5,   32'h1234_5678, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_A, 8'd0,   8'd1,   32'h7FFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_A, 8'd1,   8'd1,   32'h0001_0000, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_A, 8'd2,   8'd1,   32'hFFFF_0000, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_B, 8'd2,   8'd0,   32'h8000_0000, 1'b0, 1'b0, 64'd0},
    '{ACT_PROD,   8'd0,   8'd1,   32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_PROD,   8'd1,   8'd0,   32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_PROD,   8'd1,   8'd1,   32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_RHS,    8'd1,   8'd0,   32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_A, 8'd254, 8'd255, 32'hFEDC_BA98, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_A, 8'd255, 8'd255, 32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_B, 8'd254, 8'd0,   32'hFFFF_FFFF, 1'b0, 1'b0, 64'd0},
    '{ACT_LOAD_B, 8'd255, 8'd0,   32'h0000_0001, 1'b0, 1'b0, 64'd0},
    '{ACT_PROD,   8'd255, 8'd255, 32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_RHS,    8'd255, 8'hAA,  32'h0,         1'b0, 1'b0, 64'd0},
    '{ACT_PROD,   8'd0,   8'd255, 32'h0,         1'b1, 1'b1, 64'd0}
  };

  localparam int PHASES = 10;
  localparam phase_t SETTINGS_LIST [PHASES] = '{
    '{9'd8,   4'd15, 8,  90,  1'b1},  // widest band on a tiny matrix, saturating fill
    '{9'd1,   4'd1,  1,  50,  1'b0},  // smallest legal setting
    '{9'd0,   4'd5,  0,  50,  1'b0},  // size zero: loads dropped, requests out of size
    '{9'd511, 4'd0,  0,  80,  1'b0},  // size clamps to 256, no diagonals at all
    '{9'd16,  4'd4,  16, 110, 1'b0},  // even diagonal count
    '{9'd40,  4'd7,  40, 110, 1'b0},
    '{9'd5,   4'd2,  5,  80,  1'b0},
    '{9'd256, 4'd15, 8,  130, 1'b0},  // full size, widest band, ends filled only
    '{9'd100, 4'd9,  6,  100, 1'b0},
    '{9'd3,   4'd3,  3,  60,  1'b0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_AW-1:0]     cfg_addr_i;
  logic [SIZE_W-1:0]     cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // row[7:0] col[15:8] value[47:16]
  logic [1:0]            s_axis_tuser;   // action[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // row[7:0] col[15:8] sum[79:16]
  logic                  m_axis_tuser;   // status[0]

  // shadow of the block: configuration, both stores, and which entries hold data
  logic [SIZE_W-1:0]  size_reg;
  logic [DIAG_W-1:0]  diag_reg;
  logic signed [31:0] band_mem [BAND_DEPTH];
  bit                 band_set [BAND_DEPTH];
  logic signed [31:0] rhs_mem [MAX_SIZE];
  bit                 rhs_set [MAX_SIZE];

  entry_t sums_due [$];
  int     mismatches;
  int     stall_cycles;
  int     words_sent;
  int     tx_idle_pct;
  int     rx_idle_pct;

  banded_normal_equations u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int active_size();
    return (size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
  endfunction

  // Walk the band rows l that a request touches, in ascending order, and
  // build the saturating Q32.32 sum. Also tell whether every entry read
  // has been loaded, so random requests never read an empty entry.
  function automatic void walk_sum(input action_e act, input logic [7:0] r, c,
                                   output logic bad, output logic [63:0] sum,
                                   output bit loaded);
    int n, k, half, ri, ci, top, bot, lo, hi, l, ia, ib;
    longint acc, term;
    logic signed [64:0] wide;
    n = active_size();
    k = diag_reg;
    half = k / 2;
    ri = r;
    ci = c;
    bad = 1'b0;
    loaded = 1'b1;
    acc = 0;
    top = 0;
    bot = 1;
    if (act == ACT_PROD) begin
      if (ri >= n || ci >= n || (ri > ci ? ri - ci : ci - ri) > half) begin
        bad = 1'b1;
      end else begin
        top = (ri < ci ? ri : ci) + half;
        bot = (ri > ci ? ri : ci) + half - (k - 1);
      end
    end else begin
      if (ri >= n) begin
        bad = 1'b1;
      end else begin
        top = ri + half;
        bot = ri + half - (k - 1);
      end
    end
    if (!bad) begin
      lo = bot < 0 ? 0 : bot;
      hi = top > n - 1 ? n - 1 : top;
      for (l = lo; l <= hi; l++) begin
        ia = l * MAX_DIAG + (ri - l + half);
        if (act == ACT_PROD) begin
          ib = l * MAX_DIAG + (ci - l + half);
          loaded &= band_set[ia] && band_set[ib];
          term = longint'(band_mem[ia]) * longint'(band_mem[ib]);
        end else begin
          loaded &= band_set[ia] && rhs_set[l];
          term = longint'(band_mem[ia]) * longint'(rhs_mem[l]);
        end
        // clamp on every addition, not only at the end
        wide = acc + term;
        if (wide[64] != wide[63])
          acc = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
          acc = wide[63:0];
      end
    end
    sum = bad ? 64'd0 : acc;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Bias rows toward both ends of the matrix, where the band is clipped.
  function automatic logic [7:0] pick_row(input int n);
    int w;
    w = (n < 8) ? n : 8;
    if (n == 0)
      return 8'($urandom);
    case ($urandom_range(3))
      0: return 8'($urandom);
      1: return 8'($urandom_range(n - 1));
      2: return 8'($urandom_range(w - 1));
      default: return 8'(n - 1 - int'($urandom_range(w - 1)));
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one word; on its handshake, update the shadow stores or queue the
  // result the request must produce.
  task automatic send_word(input action_e act, input logic [7:0] r, c,
                           input logic [31:0] v, input bit typed,
                           input logic st, input logic [63:0] sm);
    entry_t due;
    logic bad;
    logic [63:0] s;
    bit loaded;
    int n, half, d;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, c, r};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);

    n = active_size();
    half = diag_reg / 2;
    case (act)
      ACT_LOAD_A: begin
        d = int'(c) - int'(r) + half;
        if (r < n && c < n && d >= 0 && d < diag_reg) begin
          band_mem[int'(r) * MAX_DIAG + d] = v;
          band_set[int'(r) * MAX_DIAG + d] = 1'b1;
        end
      end
      ACT_LOAD_B: begin
        if (r < n) begin
          rhs_mem[r] = v;
          rhs_set[r] = 1'b1;
        end
      end
      default: begin
        walk_sum(act, r, c, bad, s, loaded);
        due.status = typed ? st : bad;
        due.row    = r;
        due.col    = (act == ACT_RHS) ? 8'd0 : c;
        due.sum    = typed ? sm : s;
        sums_due.push_back(due);
      end
    endcase

    // idle pattern: sender light / receiver heavy, then swapped, then none
    words_sent++;
    if (words_sent == 600) begin
      tx_idle_pct = 49;
      rx_idle_pct = 10;
    end else if (words_sent == 1200) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [SIZE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    if (idx == REG_SIZE)
      size_reg = val;
    else if (idx == REG_DIAG)
      diag_reg = val[DIAG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every queued result, then let a trailing load or
  // request finish inside the block.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Receiver: stall at random per cycle, at the rate of the current pattern.
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    entry_t got;
    entry_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[79:16]};
      if (sums_due.size() == 0) begin
        flag_mismatch($sformatf("result row %0d col %0d with nothing expected",
                                got.row, got.col));
      end else begin
        want = sums_due.pop_front();
        if (got.status != want.status)
          flag_mismatch($sformatf("status %0b, expected %0b (row %0d col %0d)",
                                  got.status, want.status, want.row, want.col));
        if (got.row != want.row)
          flag_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
        if (got.col != want.col)
          flag_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
        if (got.sum != want.sum)
          flag_mismatch($sformatf("sum %h, expected %h (row %0d col %0d)",
                                  got.sum, want.sum, want.row, want.col));
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int p, i, r_i, c_i, d, n, k, half, roll, tries;
    action_e act;
    logic [7:0] r, c;
    logic [31:0] v;
    logic bad;
    logic [63:0] s;
    bit loaded;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_SIZE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_LOAD_A;
    m_axis_tready = 1'b0;
    size_reg      = SIZE_RST;
    diag_reg      = DIAG_RST;
    mismatches    = 0;
    stall_cycles  = 0;
    words_sent    = 0;
    tx_idle_pct   = 10;
    rx_idle_pct   = 49;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset setting
    for (i = 0; i < PROBES; i++)
      send_word(SCRIPT[i].act, SCRIPT[i].row, SCRIPT[i].col, SCRIPT[i].value,
                SCRIPT[i].typed, SCRIPT[i].status, SCRIPT[i].sum);

    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p == 0) begin
        write_reg(REG_SPARE_LO, 9'($urandom));
        write_reg(REG_SPARE_HI, 9'($urandom));
      end
      write_reg(REG_SIZE, SETTINGS_LIST[p].size);
      write_reg(REG_DIAG, SETTINGS_LIST[p].diag);
      n = active_size();
      k = diag_reg;
      half = k / 2;

      // fill every in-band entry and b element of the rows at both ends
      for (r_i = 0; r_i < n; r_i++) begin
        if (r_i < SETTINGS_LIST[p].rim_rows || r_i >= n - SETTINGS_LIST[p].rim_rows) begin
          for (d = 0; d < k; d++) begin
            c_i = r_i + d - half;
            if (c_i >= 0 && c_i < n)
              send_word(ACT_LOAD_A, 8'(r_i), 8'(c_i),
                        SETTINGS_LIST[p].hot ? 32'h8000_0000 : pick_value(),
                        1'b0, 1'b0, 64'd0);
          end
          send_word(ACT_LOAD_B, 8'(r_i), 8'd0,
                    SETTINGS_LIST[p].hot ? 32'h7FFF_FFFF : pick_value(),
                    1'b0, 1'b0, 64'd0);
        end
      end

      // random mix: overwrite band and b entries, request products and rhs
      for (i = 0; i < SETTINGS_LIST[p].random_words; i++) begin
        roll = $urandom_range(99);
        v = pick_value();
        if (roll < 45) begin
          act = (roll < 30) ? ACT_PROD : ACT_RHS;
          loaded = 1'b0;
          for (tries = 0; tries < 64 && !loaded; tries++) begin
            r = pick_row(n);
            if ($urandom_range(9) < 7)
              c = 8'(int'(r) + int'($urandom_range(2 * half + 2)) - half - 1);
            else
              c = 8'($urandom);
            walk_sum(act, r, c, bad, s, loaded);
          end
          // nothing safe found: fall back to a request that reads no entry
          if (!loaded) begin
            act = ACT_PROD;
            r = 8'd0;
            c = 8'hFF;
          end
        end else if (roll < 75 && n > 0 && k > 0) begin
          act = ACT_LOAD_A;
          r = pick_row(n);
          c = 8'(int'(r) + int'($urandom_range(k - 1)) - half);
        end else if (roll < 85) begin
          act = ACT_LOAD_A;
          r = 8'($urandom);
          c = 8'($urandom);
        end else begin
          act = ACT_LOAD_B;
          r = ($urandom_range(3) == 0) ? 8'($urandom) : pick_row(n);
          c = 8'($urandom);
        end
        send_word(act, r, c, v, 1'b0, 1'b0, 64'd0);
      end
    end

    drain();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
